// File: rtl/lmd_pkg.sv
// Shared constants, types and the Morse pattern table for the light Morse decoder.
`timescale 1ns / 1ps

package lmd_pkg;

  localparam int MAX_ELEMENTS = 5;
  localparam int COUNT_WIDTH  = 16;
  localparam int LEN_W        = $clog2(MAX_ELEMENTS + 2);
  localparam int OVF_LEN      = MAX_ELEMENTS + 1;
  localparam int NUM_CODES    = 37;
  localparam int CODE_W       = 6;
  localparam int SAMPLE_W     = 12;
  localparam int THRESH_W     = 12;
  localparam int UNIT_W       = 12;
  localparam int FLUSH_W      = 16;
  localparam int THREE_W      = UNIT_W + 2;
  localparam int SEVEN_W      = UNIT_W + 3;
  localparam int CMP_W        = COUNT_WIDTH + 3;
  localparam int FL_CMP_W     = (COUNT_WIDTH > FLUSH_W) ? COUNT_WIDTH : FLUSH_W;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLUSH     = 2'd2;

  localparam logic [CODE_W-1:0] SPACE_CODE = 6'd26;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd100;
  localparam logic [UNIT_W-1:0]   UNIT_RESET   = 12'd20;
  localparam logic [FLUSH_W-1:0]  FLUSH_RESET  = 16'd600;

  typedef logic [CODE_W-1:0] code_t;

  typedef struct packed {
    logic  two;
    code_t first;
    code_t second;
  } word_t;

  typedef struct packed {
    logic  hit;
    code_t code;
  } lookup_t;

  localparam logic [2:0] CODE_LEN [NUM_CODES] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
    3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
    3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4, 3'd0,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [4:0] CODE_BITS [NUM_CODES] = '{
    5'd1, 5'd8, 5'd10, 5'd4, 5'd0, 5'd2, 5'd6, 5'd0, 5'd0, 5'd7,
    5'd5, 5'd4, 5'd3, 5'd2, 5'd7, 5'd6, 5'd13, 5'd2, 5'd0, 5'd1,
    5'd1, 5'd1, 5'd3, 5'd9, 5'd11, 5'd12, 5'd0,
    5'd15, 5'd7, 5'd3, 5'd1, 5'd0, 5'd16, 5'd24, 5'd28, 5'd30, 5'd31
  };

  function automatic lookup_t lookup(input logic [LEN_W-1:0] len,
                                     input logic [MAX_ELEMENTS-1:0] pat);
    lookup_t r;
    r = '0;
    if (len != '0 && len <= LEN_W'(MAX_ELEMENTS)) begin
      for (int k = NUM_CODES - 1; k >= 0; k--) begin
        if (len == LEN_W'(CODE_LEN[k]) && pat == MAX_ELEMENTS'(CODE_BITS[k])) begin
          r.hit  = 1'b1;
          r.code = CODE_W'(k);
        end
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/lmd_if.sv
// Handshake interfaces for the sample, character and configuration channels.
`timescale 1ns / 1ps

interface lmd_in_if;
  logic                          valid;
  logic                          ready;
  logic [lmd_pkg::SAMPLE_W-1:0]  light_sample;
  modport source (output valid, output light_sample, input ready);
  modport sink   (input valid, input light_sample, output ready);
endinterface

interface lmd_out_if;
  logic                        valid;
  logic                        ready;
  logic [lmd_pkg::CODE_W-1:0]  char_code;
  logic                        last;
  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface lmd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lmd_pkg::CFG_IDX_W-1:0]   index;
  logic [lmd_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lmd_front.sv
// Sample classifier: threshold, run counting, element shifting and letter lookup.
`timescale 1ns / 1ps

module lmd_front (
  input  logic                clk,
  input  logic                rst_n,
  lmd_in_if.sink              in_s,
  lmd_cfg_if.sink             cfg_s,
  input  logic                q_full,
  output logic                push,
  output lmd_pkg::word_t      push_word
);

  logic [lmd_pkg::THRESH_W-1:0]     thr_r;
  logic [lmd_pkg::FLUSH_W-1:0]      flush_r;
  logic [lmd_pkg::THREE_W-1:0]      three_r;
  logic [lmd_pkg::SEVEN_W-1:0]      seven_r;

  logic                             lio_r, lio_nxt;
  logic                             off_r, off_nxt;
  logic [lmd_pkg::COUNT_WIDTH-1:0]  run_r, run_nxt;
  logic [lmd_pkg::MAX_ELEMENTS-1:0] pat_r, pat_nxt;
  logic [lmd_pkg::LEN_W-1:0]        len_r, len_nxt;

  logic                             fire;
  logic                             on;
  logic                             gt3, gt7;
  logic                             end_req, space;
  logic [lmd_pkg::MAX_ELEMENTS-1:0] sel_pat;
  logic [lmd_pkg::LEN_W-1:0]        sel_len;
  lmd_pkg::lookup_t                 hit;
  logic                             letter;
  logic [lmd_pkg::UNIT_W-1:0]       cfg_unit;

  assign in_s.ready  = ~q_full;
  assign cfg_s.ready = 1'b1;
  assign fire        = in_s.valid & ~q_full;
  assign cfg_unit    = cfg_s.data[lmd_pkg::UNIT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= lmd_pkg::THRESH_RESET;
      flush_r <= lmd_pkg::FLUSH_RESET;
      three_r <= lmd_pkg::THREE_W'(lmd_pkg::UNIT_RESET) * lmd_pkg::THREE_W'(3);
      seven_r <= lmd_pkg::SEVEN_W'(lmd_pkg::UNIT_RESET) * lmd_pkg::SEVEN_W'(7);
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        lmd_pkg::REG_THRESHOLD: begin
          thr_r <= cfg_s.data[lmd_pkg::THRESH_W-1:0];
        end
        lmd_pkg::REG_UNIT: begin
          three_r <= {cfg_unit, 1'b0} + lmd_pkg::THREE_W'(cfg_unit);
          seven_r <= {cfg_unit, 2'b0} + {1'b0, cfg_unit, 1'b0}
                     + lmd_pkg::SEVEN_W'(cfg_unit);
        end
        lmd_pkg::REG_FLUSH: begin
          flush_r <= cfg_s.data[lmd_pkg::FLUSH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lio_r <= 1'b0;
      off_r <= 1'b0;
      run_r <= '0;
      pat_r <= '0;
      len_r <= '0;
    end else begin
      lio_r <= lio_nxt;
      off_r <= off_nxt;
      run_r <= run_nxt;
      pat_r <= pat_nxt;
      len_r <= len_nxt;
    end
  end

  assign on  = in_s.light_sample > thr_r;
  assign gt3 = lmd_pkg::CMP_W'(run_r) > lmd_pkg::CMP_W'(three_r);
  assign gt7 = lmd_pkg::CMP_W'(run_r) > lmd_pkg::CMP_W'(seven_r);

  always_comb begin
    lio_nxt = lio_r;
    off_nxt = off_r;
    run_nxt = run_r;
    pat_nxt = pat_r;
    len_nxt = len_r;
    sel_pat = pat_r;
    sel_len = len_r;
    end_req = 1'b0;
    space   = 1'b0;
    if (fire) begin
      if (on != lio_r) begin
        if (on) begin
          if (off_r && gt3) begin
            end_req = 1'b1;
            space   = gt7;
            pat_nxt = '0;
            len_nxt = '0;
          end
          off_nxt = 1'b0;
        end else begin
          if (len_r < lmd_pkg::LEN_W'(lmd_pkg::MAX_ELEMENTS)) begin
            pat_nxt = {pat_r[lmd_pkg::MAX_ELEMENTS-2:0], gt3};
            len_nxt = len_r + 1'b1;
          end else begin
            len_nxt = lmd_pkg::LEN_W'(lmd_pkg::OVF_LEN);
          end
          off_nxt = 1'b1;
        end
        lio_nxt = on;
        run_nxt = lmd_pkg::COUNT_WIDTH'(1);
      end else if (run_r != '1) begin
        run_nxt = run_r + 1'b1;
      end
      if (!lio_nxt && len_nxt != '0 &&
          lmd_pkg::FL_CMP_W'(run_nxt) >= lmd_pkg::FL_CMP_W'(flush_r)) begin
        end_req = 1'b1;
        sel_pat = pat_nxt;
        sel_len = len_nxt;
        pat_nxt = '0;
        len_nxt = '0;
        off_nxt = 1'b0;
      end
    end
  end

  assign hit    = lmd_pkg::lookup(sel_len, sel_pat);
  assign letter = end_req & hit.hit;

  always_comb begin
    push_word = '0;
    if (letter) begin
      push_word.first  = hit.code;
      push_word.second = lmd_pkg::SPACE_CODE;
      push_word.two    = space;
    end else begin
      push_word.first  = lmd_pkg::SPACE_CODE;
    end
  end

  assign push = fire & (letter | space);

endmodule

// File: rtl/lmd_fifo.sv
// Short queue of result words between the classifier and the output stage.
`timescale 1ns / 1ps

module lmd_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lmd_pkg::word_t   push_word,
  input  logic             pop,
  output logic             full,
  output logic             nonempty,
  output lmd_pkg::word_t   head
);

  lmd_pkg::word_t                    mem [lmd_pkg::FIFO_DEPTH];
  logic [lmd_pkg::FIFO_PTR_W-1:0]    wr_r, rd_r;
  logic [lmd_pkg::FIFO_CNT_W-1:0]    cnt_r;

  assign full     = cnt_r == lmd_pkg::FIFO_CNT_W'(lmd_pkg::FIFO_DEPTH);
  assign nonempty = cnt_r != '0;
  assign head     = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/lmd_back.sv
// Output stage: unpacks queued words into one character per handshake.
`timescale 1ns / 1ps

module lmd_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_nonempty,
  input  lmd_pkg::word_t   q_head,
  output logic             pop,
  lmd_out_if.source        out_s
);

  logic            hold_valid_r;
  lmd_pkg::word_t  hold_r;
  logic            second_r;
  logic            is_last;
  logic            take;

  assign is_last         = ~hold_r.two | second_r;
  assign take            = out_s.ready & hold_valid_r;
  assign pop             = q_nonempty & (~hold_valid_r | (take & is_last));
  assign out_s.valid     = hold_valid_r;
  assign out_s.char_code = second_r ? hold_r.second : hold_r.first;
  assign out_s.last      = is_last;

  always_ff @(posedge clk) begin
    if (pop) begin
      hold_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      second_r     <= 1'b0;
    end else if (pop) begin
      hold_valid_r <= 1'b1;
      second_r     <= 1'b0;
    end else if (take) begin
      if (is_last) begin
        hold_valid_r <= 1'b0;
        second_r     <= 1'b0;
      end else begin
        second_r     <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/light_morse_decoder.sv
// Top level of the light-pulse Morse decoder.
//
//   channel  dir  payload                    handshake
//   in_s     in   light_sample[11:0]         valid/ready
//   out_s    out  char_code[5:0], last       valid/ready
//   cfg_s    in   index[1:0], data[15:0]     valid/ready (ready always high)
//
// One sample is taken per cycle while the four-word queue has room; classification,
// run counting and table lookup finish in the cycle the sample is taken.
// A sample yields zero, one or two characters; the output stage hands out one per
// cycle while out_s.ready is high, so a letter followed by a space takes two output handshakes.
// Reset (synchronous, active low) restores register defaults and empties the queue.
// Output stalls back up through the queue into in_s.ready; no state is lost.
`timescale 1ns / 1ps

module light_morse_decoder (
  input  logic        clk,
  input  logic        rst_n,
  lmd_in_if.sink      in_s,
  lmd_out_if.source   out_s,
  lmd_cfg_if.sink     cfg_s
);

  logic            q_full;
  logic            q_nonempty;
  logic            push;
  logic            pop;
  lmd_pkg::word_t  push_word;
  lmd_pkg::word_t  q_head;

  lmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_s),
    .cfg_s     (cfg_s),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  lmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  lmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .pop        (pop),
    .out_s      (out_s)
  );

endmodule

// File: rtl/lmd_checker.sv
// Port-level assertions for the light Morse decoder, bound to the top level.
`timescale 1ns / 1ps

module lmd_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [lmd_pkg::CODE_W-1:0]  char_code,
  input  logic                        out_last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(out_last))
    else $error("stalled output changed");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> char_code <= lmd_pkg::CODE_W'(lmd_pkg::NUM_CODES - 1))
    else $error("character code out of range");

  a_space_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && char_code == lmd_pkg::SPACE_CODE |-> out_last)
    else $error("space not marked last");

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("second character of a sample missing");

endmodule

bind light_morse_decoder lmd_checker u_lmd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_s.valid),
  .out_ready (out_s.ready),
  .char_code (out_s.char_code),
  .out_last  (out_s.last)
);

// File: sim/morse_checker.sv
// Checker: predicts decoded characters from accepted samples and compares the output words.
`timescale 1ns / 1ps

module morse_checker
  import lmd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  lmd_in_if    in_w,
  lmd_out_if   out_w,
  lmd_cfg_if   cfg_w,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    code_t code;
    logic  last;
  } char_word_t;

  localparam logic [COUNT_WIDTH-1:0] RUN_MAX = '1;

  logic [THRESH_W-1:0]     thr;
  logic [UNIT_W-1:0]       unit;
  logic [FLUSH_W-1:0]      flush_lim;
  logic                    light_on;
  logic                    gap_open;
  logic [COUNT_WIDTH-1:0]  run_len;
  logic [MAX_ELEMENTS-1:0] elems;
  logic [LEN_W-1:0]        elem_cnt;

  char_word_t expected_chars[$];
  code_t      fresh_codes[$];

  function automatic string morse_of(input int k);
    case (k)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      25: return "--..";
      27: return ".----";
      28: return "..---";
      29: return "...--";
      30: return "....-";
      31: return ".....";
      32: return "-....";
      33: return "--...";
      34: return "---..";
      35: return "----.";
      36: return "-----";
      default: return "";
    endcase
  endfunction

  task automatic close_letter();
    string                   s;
    logic [MAX_ELEMENTS-1:0] bits;
    bit                      found;
    found = 1'b0;
    if (elem_cnt >= 1 && elem_cnt <= MAX_ELEMENTS) begin
      for (int k = 0; k < NUM_CODES; k++) begin
        s = morse_of(k);
        if (!found && s.len() > 0 && s.len() == int'(elem_cnt)) begin
          bits = '0;
          for (int i = 0; i < s.len(); i++) begin
            bits = {bits[MAX_ELEMENTS-2:0], s[i] == "-"};
          end
          if (bits == elems) begin
            found = 1'b1;
            fresh_codes.push_back(CODE_W'(k));
          end
        end
      end
    end
    elems    = '0;
    elem_cnt = '0;
  endtask

  task automatic decode_sample(input logic [SAMPLE_W-1:0] smp);
    logic        lit;
    int unsigned three;
    int unsigned seven;
    char_word_t  w;
    lit   = smp > thr;
    three = 3 * unit;
    seven = 7 * unit;
    fresh_codes.delete();
    if (lit != light_on) begin
      if (lit) begin
        if (gap_open && run_len > three) begin
          close_letter();
          if (run_len > seven) begin
            fresh_codes.push_back(SPACE_CODE);
          end
        end
        gap_open = 1'b0;
      end else begin
        if (elem_cnt < MAX_ELEMENTS) begin
          elems    = {elems[MAX_ELEMENTS-2:0], run_len > three};
          elem_cnt = elem_cnt + 1'b1;
        end else begin
          elem_cnt = LEN_W'(OVF_LEN);
        end
        gap_open = 1'b1;
      end
      light_on = lit;
      run_len  = 1;
    end else if (run_len != RUN_MAX) begin
      run_len = run_len + 1'b1;
    end
    if (!light_on && elem_cnt != 0 && run_len >= flush_lim) begin
      close_letter();
      gap_open = 1'b0;
    end
    foreach (fresh_codes[i]) begin
      w.code = fresh_codes[i];
      w.last = (i == fresh_codes.size() - 1);
      expected_chars.push_back(w);
    end
  endtask

  always @(posedge clk) begin : watch
    char_word_t want;
    if (!rst_n) begin
      thr        = THRESH_RESET;
      unit       = UNIT_RESET;
      flush_lim  = FLUSH_RESET;
      light_on   = 1'b0;
      gap_open   = 1'b0;
      run_len    = '0;
      elems      = '0;
      elem_cnt   = '0;
      fail_count = 0;
      expected_chars.delete();
    end else begin
      if (cfg_w.valid && cfg_w.ready) begin
        case (cfg_w.index)
          REG_THRESHOLD: thr = cfg_w.data[THRESH_W-1:0];
          REG_UNIT:      unit = cfg_w.data[UNIT_W-1:0];
          REG_FLUSH:     flush_lim = cfg_w.data[FLUSH_W-1:0];
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready) begin
        decode_sample(in_w.light_sample);
      end
      if (out_w.valid && out_w.ready) begin
        if (expected_chars.size() == 0) begin
          $error("char_code: expected none, actual %0d", out_w.char_code);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          if (out_w.char_code !== want.code) begin
            $error("char_code: expected %0d, actual %0d", want.code, out_w.char_code);
            fail_count++;
          end
          if (out_w.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, out_w.last);
            fail_count++;
          end
        end
      end
    end
    pending = expected_chars.size();
  end

endmodule

// File: sim/tb_top.sv
// Testbench top: clock, reset, sample stimulus and verdict for the light Morse decoder.
`timescale 1ns / 1ps

module tb_top;
  import lmd_pkg::*;

  localparam int LIMIT_CYCLES   = 2_000_000;
  localparam int RANDOM_SAMPLES = 1000;
  localparam int PHASES         = 8;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  int          src_idle_pct = 0;
  int          sink_stall_pct = 0;
  int          samples_sent = 0;

  logic [THRESH_W-1:0] thr_now;
  logic [UNIT_W-1:0]   unit_now;
  logic [FLUSH_W-1:0]  flush_now;

  lmd_in_if  in_w ();
  lmd_out_if out_w ();
  lmd_cfg_if cfg_w ();

  light_morse_decoder u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_w),
    .out_s (out_w),
    .cfg_s (cfg_w)
  );

  morse_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_w       (in_w),
    .out_w      (out_w),
    .cfg_w      (cfg_w),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always begin
    out_w.ready = ($urandom_range(99, 0) >= sink_stall_pct);
    @(negedge clk);
  end

  function automatic int span(input int lo, input int hi);
    if (lo < 1) lo = 1;
    if (hi < lo) hi = lo;
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [SAMPLE_W-1:0] level(input bit lit);
    if (lit) begin
      if (thr_now == '1) return '1;
      if ($urandom_range(9, 0) == 0) return thr_now + 1'b1;
      return SAMPLE_W'($urandom_range(SAMPLE_MAX, thr_now + 1));
    end
    if ($urandom_range(9, 0) == 0) return thr_now;
    return SAMPLE_W'($urandom_range(thr_now, 0));
  endfunction

  task automatic put_sample(input logic [SAMPLE_W-1:0] v);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_w.valid = 1'b0;
      @(negedge clk);
    end
    in_w.valid        = 1'b1;
    in_w.light_sample = v;
    @(posedge clk);
    while (!(in_w.valid && in_w.ready)) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic send_run(input bit lit, input int n);
    repeat (n) put_sample(level(lit));
  endtask

  task automatic pulse(input int mark_len, input int gap_len);
    send_run(1'b1, mark_len);
    send_run(1'b0, gap_len);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    cfg_w.valid = 1'b1;
    cfg_w.index = idx;
    cfg_w.data  = CFG_DATA_W'(val);
    @(posedge clk);
    while (!(cfg_w.valid && cfg_w.ready)) @(posedge clk);
    @(negedge clk);
    cfg_w.valid = 1'b0;
  endtask

  task automatic drain();
    in_w.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic configure(input int unsigned t, input int unsigned u, input int unsigned f);
    drain();
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_UNIT, u);
    write_reg(REG_FLUSH, f);
    thr_now   = THRESH_W'(t);
    unit_now  = UNIT_W'(u);
    flush_now = FLUSH_W'(f);
  endtask

  task automatic send_letter();
    int u;
    int n_elem;
    int pick;
    u    = unit_now;
    pick = $urandom_range(99, 0);
    n_elem = (pick < 75) ? $urandom_range(4, 1) : (pick < 93) ? 5 : $urandom_range(7, 6);
    for (int i = 0; i < n_elem; i++) begin
      if (i != 0) send_run(1'b0, span(1, 3 * u));
      if ($urandom_range(1, 0) == 1) send_run(1'b1, span(3 * u + 1, 5 * u + 1));
      else send_run(1'b1, span(1, 3 * u));
    end
    pick = $urandom_range(99, 0);
    if (pick < 50) send_run(1'b0, span(3 * u + 1, 7 * u));
    else if (pick < 80) send_run(1'b0, span(7 * u + 1, 9 * u + 1));
    else if (pick < 90) send_run(1'b0, span(flush_now, flush_now + 4));
    else repeat ($urandom_range(6, 1)) put_sample(SAMPLE_W'($urandom));
  endtask

  initial begin
    int goal;
    int t;
    int u;
    int f;
    rst_n             = 1'b0;
    in_w.valid        = 1'b0;
    in_w.light_sample = '0;
    cfg_w.valid       = 1'b0;
    cfg_w.index       = REG_THRESHOLD;
    cfg_w.data        = '0;
    thr_now           = THRESH_RESET;
    unit_now          = UNIT_RESET;
    flush_now         = FLUSH_RESET;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // dot at three units, word gap, dash, then flush on a long idle
    send_run(1'b1, 60);
    send_run(1'b0, 141);
    send_run(1'b1, 61);
    send_run(1'b0, 601);

    configure(2048, 1, 20);
    put_sample('1);
    put_sample('0);
    put_sample(12'd2049);
    put_sample(12'd2048);
    pulse(1, 1);
    pulse(1, 1);
    pulse(1, 1);
    pulse(1, 5);
    pulse(3, 3);
    pulse(4, 7);
    pulse(1, 1);
    pulse(1, 1);
    pulse(4, 1);
    pulse(4, 8);
    pulse(2, 25);

    configure(2048, 0, 20);
    pulse(1, 1);
    pulse(1, 25);

    configure(2048, 1, 0);
    pulse(2, 3);
    pulse(5, 2);

    configure(SAMPLE_MAX, 1, 20);
    repeat (8) put_sample(SAMPLE_W'($urandom));

    configure(0, 1, 20);
    pulse(3, 4);
    pulse(1, 4);

    for (int ph = 0; ph < PHASES; ph++) begin
      t = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(SAMPLE_MAX - 1, 0);
      u = ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(3, 1);
      f = ($urandom_range(7, 0) == 0) ? 0 : $urandom_range(48, 6);
      configure(t, u, f);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 45; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 45; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      goal = samples_sent + RANDOM_SAMPLES / PHASES;
      while (samples_sent < goal) send_letter();
    end

    drain();
    repeat (16) @(negedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/lmd_pkg.sv
rtl/lmd_if.sv
rtl/lmd_front.sv
rtl/lmd_fifo.sv
rtl/lmd_back.sv
rtl/light_morse_decoder.sv
rtl/lmd_checker.sv
sim/morse_checker.sv
sim/tb_top.sv
